FILE: rtl/core/pmp_pkg.sv
// ----------------------------------------------------------------------------
// Puck motion predictor package
// Shared constants, codes, configuration, command and status types.
// ----------------------------------------------------------------------------
package pmp_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracB  = 16;
  localparam int unsigned DivW   = 64;
  localparam int unsigned PosW   = 50;
  localparam int unsigned SampleLimit = 63;
  localparam logic [19:0] UsPerSec = 20'd1000000;

  typedef enum logic [1:0] {
    CMD_MOVE    = 2'd0,
    CMD_ORIENT  = 2'd1,
    CMD_PREDICT = 2'd2,
    CMD_TRAJ    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_KEPT   = 2'd1,
    ST_NOTRAJ = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_TABLE_WIDTH   = 3'd0,
    REG_TABLE_LENGTH  = 3'd1,
    REG_RADIUS        = 3'd2,
    REG_REST_SPEED_SQ = 3'd3,
    REG_SPACING_US    = 3'd4,
    REG_MAX_SAMPLES   = 3'd5
  } reg_e;

  typedef struct packed {
    logic [30:0] table_width;
    logic [30:0] table_length;
    logic [30:0] radius;
    logic [31:0] rest_speed_sq;
    logic [19:0] spacing_us;
    logic [5:0]  max_samples;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_VX,
    OP_SET_VX,
    OP_DIV_VY,
    OP_SET_VY,
    OP_MOVE,
    OP_ORIENT,
    OP_NOTRAJ,
    OP_TOA_DIV,
    OP_TOA_ZERO,
    OP_TOA_SET,
    OP_SCALE,
    OP_N_DIV,
    OP_N_SET,
    OP_T_DIV,
    OP_T_SET,
    OP_PRED,
    OP_SQX,
    OP_SQY,
    OP_REST,
    OP_MULX,
    OP_POSX,
    OP_POSY,
    OP_MODX,
    OP_FOLDX,
    OP_MODY,
    OP_FOLDY,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    cmd_e cmd;
    logic dt_zero;
    logic notraj;
    logic num_ok;
    logic n_zero;
    logic rest;
    logic last;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_VX_WAIT,
    S_VY_START,
    S_VY_WAIT,
    S_MOVE,
    S_ORIENT,
    S_NOTRAJ,
    S_TOA_WAIT,
    S_SCALE,
    S_N_START,
    S_N_WAIT,
    S_T_START,
    S_T_WAIT,
    S_SQX,
    S_SQY,
    S_REST,
    S_MULX,
    S_POSX,
    S_POSY,
    S_MODX,
    S_MODX_WAIT,
    S_MODY,
    S_MODY_WAIT,
    S_EMIT
  } ctrl_state_e;

endpackage

FILE: rtl/core/pmp_div.sv
// ----------------------------------------------------------------------------
// Puck motion predictor divider
// Restoring divider giving one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
module pmp_div import pmp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic [DivW-1:0] quo_o,
  output logic [DivW-1:0] rem_o,
  output logic            done_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic [DivW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q;
  logic [DivW:0]   trial, diff;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    diff  = trial - {1'b0, dvs_q};
    if (!diff[DivW]) begin
      rem_d = diff[DivW-1:0];
    end else begin
      rem_d = trial[DivW-1:0];
    end
    quo_d = {quo_q[DivW-2:0], ~diff[DivW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

FILE: rtl/core/pmp_ctrl.sv
// ----------------------------------------------------------------------------
// Puck motion predictor controller
// State machine that sequences the datapath for each command.
// ----------------------------------------------------------------------------
module pmp_ctrl import pmp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.cmd)
          CMD_MOVE: begin
            if (stat_i.dt_zero) begin
              state_d = S_MOVE;
            end else begin
              op_o    = OP_DIV_VX;
              state_d = S_VX_WAIT;
            end
          end
          CMD_ORIENT: state_d = S_ORIENT;
          CMD_PREDICT: begin
            op_o    = OP_PRED;
            state_d = S_SQX;
          end
          CMD_TRAJ: begin
            if (stat_i.notraj) begin
              state_d = S_NOTRAJ;
            end else if (stat_i.num_ok) begin
              op_o    = OP_TOA_DIV;
              state_d = S_TOA_WAIT;
            end else begin
              op_o    = OP_TOA_ZERO;
              state_d = S_SCALE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_VX_WAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_SET_VX;
          state_d = S_VY_START;
        end
      end
      S_VY_START: begin
        op_o    = OP_DIV_VY;
        state_d = S_VY_WAIT;
      end
      S_VY_WAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_SET_VY;
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        if (!stat_i.out_busy) begin
          op_o    = OP_MOVE;
          state_d = S_IDLE;
        end
      end
      S_ORIENT: begin
        if (!stat_i.out_busy) begin
          op_o    = OP_ORIENT;
          state_d = S_IDLE;
        end
      end
      S_NOTRAJ: begin
        if (!stat_i.out_busy) begin
          op_o    = OP_NOTRAJ;
          state_d = S_IDLE;
        end
      end
      S_TOA_WAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_TOA_SET;
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        op_o    = OP_SCALE;
        state_d = S_N_START;
      end
      S_N_START: begin
        op_o    = OP_N_DIV;
        state_d = S_N_WAIT;
      end
      S_N_WAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_N_SET;
          state_d = S_T_START;
        end
      end
      S_T_START: begin
        if (stat_i.n_zero) begin
          state_d = S_SQX;
        end else begin
          op_o    = OP_T_DIV;
          state_d = S_T_WAIT;
        end
      end
      S_T_WAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_T_SET;
          state_d = S_SQX;
        end
      end
      S_SQX: begin
        op_o    = OP_SQX;
        state_d = S_SQY;
      end
      S_SQY: begin
        op_o    = OP_SQY;
        state_d = S_REST;
      end
      S_REST: begin
        op_o    = OP_REST;
        state_d = stat_i.rest ? S_EMIT : S_MULX;
      end
      S_MULX: begin
        op_o    = OP_MULX;
        state_d = S_POSX;
      end
      S_POSX: begin
        op_o    = OP_POSX;
        state_d = S_POSY;
      end
      S_POSY: begin
        op_o    = OP_POSY;
        state_d = S_MODX;
      end
      S_MODX: begin
        op_o    = OP_MODX;
        state_d = S_MODX_WAIT;
      end
      S_MODX_WAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_FOLDX;
          state_d = S_MODY;
        end
      end
      S_MODY: begin
        op_o    = OP_MODY;
        state_d = S_MODY_WAIT;
      end
      S_MODY_WAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_FOLDY;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          op_o    = OP_EMIT;
          state_d = stat_i.last ? S_IDLE : S_T_START;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/pmp_dp.sv
// ----------------------------------------------------------------------------
// Puck motion predictor datapath
// Motion state, shared multiplier and divider, wall folding, result register.
// ----------------------------------------------------------------------------
module pmp_dp import pmp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_op_e             op_i,
  output dp_stat_t           stat_o,
  input  cfg_t               cfg_i,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic [31:0]        dt_i,
  input  logic               include_return_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [31:0]        sample_time_o,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } fold_t;

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [32:0] n;
    n = -(33'(v));
    if (n > 33'sd2147483647) begin
      return 32'sh7fffffff;
    end
    return n[31:0];
  endfunction

  function automatic logic signed [32:0] span(input logic [30:0] size,
                                              input logic [30:0] r);
    return $signed({2'b00, size}) - $signed({1'b0, r, 1'b0});
  endfunction

  function automatic logic [DivW-1:0] period(input logic [30:0] size,
                                             input logic [30:0] r);
    logic signed [32:0] rng;
    rng = span(size, r);
    if (rng <= 0) begin
      return DivW'(1);
    end
    return DivW'({rng[31:0], 1'b0});
  endfunction

  function automatic fold_t fold(input logic [30:0] size, input logic [30:0] r,
                                 input logic neg, input logic [32:0] rem,
                                 input logic signed [31:0] v);
    logic signed [32:0] rng;
    logic [32:0]        per, m;
    logic signed [34:0] p;
    fold_t              f;
    rng   = span(size, r);
    per   = {rng[31:0], 1'b0};
    m     = (neg && rem != '0) ? per - rem : rem;
    f.vel = v;
    if (rng <= 0) begin
      p = 35'(r);
    end else if ($signed({1'b0, m}) < 34'(rng)) begin
      p = 35'(r) + 35'(m);
    end else begin
      p     = 35'(size) - 35'(r) - (35'(m) - 35'(rng));
      f.vel = neg_sat(v);
    end
    f.pos = p[31:0];
    return f;
  endfunction

  function automatic logic signed [31:0] div_vel(input logic [DivW-1:0] q,
                                                 input logic neg);
    if (q >= DivW'(64'h8000_0000)) begin
      return neg ? 32'sh80000000 : 32'sh7fffffff;
    end
    return neg ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  cmd_e               cmd_q;
  logic signed [31:0] nx_q, ny_q, ivx_q, ivy_q;
  logic [31:0]        dt_q;
  logic               inc_q;
  logic signed [31:0] cx_q, cy_q, cvx_q, cvy_q;
  logic [31:0]        toa_q, t_q;
  logic [5:0]         n_q, idx_q;
  logic [63:0]        prod_q, prod_d;
  logic [47:0]        acc_q;
  logic signed [PosW-1:0] px_q, py_q;
  logic signed [31:0] fpx_q, fpy_q, fvx_q, fvy_q;

  logic               out_valid_q;
  logic [31:0]        o_time_q;
  logic signed [31:0] o_px_q, o_py_q, o_vx_q, o_vy_q;
  status_e            o_st_q;
  logic               o_last_q;

  logic [31:0]        ax, ay, mul_a, mul_b;
  logic signed [32:0] dx, dy;
  logic [32:0]        dmx, dmy;
  logic signed [35:0] effp, effs, num;
  logic [35:0]        nmag;
  logic               vy_pos, num_ok, last_c, rest_c, div_start;
  logic [48:0]        speed_sq;
  logic [PosW-1:0]    disp;
  logic signed [PosW:0] pdx, pdy;
  logic [PosW:0]      pmx, pmy;
  logic [19:0]        per_us;
  logic [DivW-1:0]    dvd, dvs, quo, rem;
  logic               div_done;
  fold_t              fx, fy;

  always_comb begin
    ax     = cvx_q[31] ? 32'(-cvx_q) : cvx_q;
    ay     = cvy_q[31] ? 32'(-cvy_q) : cvy_q;
    dx     = 33'(nx_q) - 33'(cx_q);
    dy     = 33'(ny_q) - 33'(cy_q);
    dmx    = dx[32] ? 33'(-dx) : 33'(dx);
    dmy    = dy[32] ? 33'(-dy) : 33'(dy);
    vy_pos = !cvy_q[31] && (cvy_q != '0);
    effp   = 36'(cy_q) - $signed(36'(cfg_i.radius));
    effs   = $signed(36'(cfg_i.table_length)) - $signed(36'({cfg_i.radius, 1'b0}));
    num    = vy_pos ? (effs <<< 1) - effp : -effp;
    nmag   = num[35] ? 36'(-num) : 36'(num);
    num_ok = (num != '0) && (!num[35] == vy_pos);
    last_c = (cmd_q != CMD_TRAJ) || (idx_q == n_q);
    speed_sq = {1'b0, acc_q} + 49'(prod_q[63:FracB]);
    rest_c = speed_sq <= 49'(cfg_i.rest_speed_sq);
    disp   = PosW'(prod_q[63:FracB]);
    pdx    = (PosW+1)'(px_q) - $signed((PosW+1)'(cfg_i.radius));
    pdy    = (PosW+1)'(py_q) - $signed((PosW+1)'(cfg_i.radius));
    pmx    = pdx[PosW] ? (PosW+1)'(-pdx) : (PosW+1)'(pdx);
    pmy    = pdy[PosW] ? (PosW+1)'(-pdy) : (PosW+1)'(pdy);
    per_us = (cfg_i.spacing_us == '0) ? 20'd1 : cfg_i.spacing_us;
    fx     = fold(cfg_i.table_width, cfg_i.radius, pdx[PosW], rem[32:0], cvx_q);
    fy     = fold(cfg_i.table_length, cfg_i.radius, pdy[PosW], rem[32:0], cvy_q);
  end

  always_comb begin
    mul_a = ax;
    mul_b = ax;
    case (op_i)
      OP_SQY:   begin mul_a = ay;    mul_b = ay; end
      OP_MULX:  begin mul_a = ax;    mul_b = t_q; end
      OP_POSX:  begin mul_a = ay;    mul_b = t_q; end
      OP_SCALE: begin mul_a = toa_q; mul_b = 32'(UsPerSec); end
      default:  begin mul_a = ax;    mul_b = ax; end
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    div_start = 1'b1;
    dvd       = '0;
    dvs       = DivW'(1);
    unique case (op_i)
      OP_DIV_VX: begin
        dvd = DivW'({dmx, {FracB{1'b0}}});
        dvs = DivW'(dt_q);
      end
      OP_DIV_VY: begin
        dvd = DivW'({dmy, {FracB{1'b0}}});
        dvs = DivW'(dt_q);
      end
      OP_TOA_DIV: begin
        dvd = DivW'({nmag, {FracB{1'b0}}});
        dvs = DivW'(ay);
      end
      OP_N_DIV: begin
        dvd = prod_q;
        dvs = DivW'({per_us, {FracB{1'b0}}});
      end
      OP_T_DIV: begin
        dvd = DivW'(38'(idx_q) * 38'(toa_q));
        dvs = DivW'(n_q);
      end
      OP_MODX: begin
        dvd = DivW'(pmx);
        dvs = period(cfg_i.table_width, cfg_i.radius);
      end
      OP_MODY: begin
        dvd = DivW'(pmy);
        dvs = period(cfg_i.table_length, cfg_i.radius);
      end
      default: div_start = 1'b0;
    endcase
  end

  pmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .quo_o      (quo),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q        <= '0;
      cy_q        <= '0;
      cvx_q       <= '0;
      cvy_q       <= '0;
      cmd_q       <= CMD_MOVE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (op_i)
        OP_LOAD:   cmd_q <= cmd_e'(cmd_i);
        OP_SET_VX: cvx_q <= div_vel(quo, dx[32]);
        OP_SET_VY: cvy_q <= div_vel(quo, dy[32]);
        OP_MOVE: begin
          cx_q <= nx_q;
          cy_q <= ny_q;
        end
        OP_ORIENT: begin
          cx_q  <= nx_q;
          cy_q  <= ny_q;
          cvx_q <= ivx_q;
          cvy_q <= ivy_q;
        end
        default: begin
        end
      endcase
      if (op_i == OP_MOVE || op_i == OP_ORIENT || op_i == OP_NOTRAJ ||
          op_i == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        nx_q  <= pos_x_i;
        ny_q  <= pos_y_i;
        ivx_q <= vel_x_i;
        ivy_q <= vel_y_i;
        dt_q  <= dt_i;
        inc_q <= include_return_i;
      end
      OP_MOVE: begin
        o_time_q <= '0;
        o_px_q   <= nx_q;
        o_py_q   <= ny_q;
        o_vx_q   <= cvx_q;
        o_vy_q   <= cvy_q;
        o_st_q   <= (dt_q == '0) ? ST_KEPT : ST_OK;
        o_last_q <= 1'b1;
      end
      OP_ORIENT: begin
        o_time_q <= '0;
        o_px_q   <= nx_q;
        o_py_q   <= ny_q;
        o_vx_q   <= ivx_q;
        o_vy_q   <= ivy_q;
        o_st_q   <= ST_OK;
        o_last_q <= 1'b1;
      end
      OP_NOTRAJ: begin
        o_time_q <= '0;
        o_px_q   <= '0;
        o_py_q   <= '0;
        o_vx_q   <= '0;
        o_vy_q   <= '0;
        o_st_q   <= ST_NOTRAJ;
        o_last_q <= 1'b1;
      end
      OP_TOA_ZERO: toa_q <= '0;
      OP_TOA_SET:  toa_q <= (quo > DivW'(32'hffff_ffff)) ? 32'hffff_ffff : quo[31:0];
      OP_SCALE:    prod_q <= prod_d;
      OP_N_SET: begin
        n_q   <= (quo > DivW'(cfg_i.max_samples)) ? cfg_i.max_samples : quo[5:0];
        idx_q <= '0;
        t_q   <= '0;
      end
      OP_T_SET: t_q <= quo[31:0];
      OP_PRED:  t_q <= dt_q;
      OP_SQX:   prod_q <= prod_d;
      OP_SQY: begin
        acc_q  <= prod_q[63:FracB];
        prod_q <= prod_d;
      end
      OP_REST: begin
        fpx_q <= cx_q;
        fpy_q <= cy_q;
        fvx_q <= '0;
        fvy_q <= '0;
      end
      OP_MULX: prod_q <= prod_d;
      OP_POSX: begin
        px_q   <= PosW'(cx_q) + (cvx_q[31] ? PosW'(-disp) : $signed(disp));
        prod_q <= prod_d;
      end
      OP_POSY: py_q <= PosW'(cy_q) + (cvy_q[31] ? PosW'(-disp) : $signed(disp));
      OP_FOLDX: begin
        fpx_q <= fx.pos;
        fvx_q <= fx.vel;
      end
      OP_FOLDY: begin
        fpy_q <= fy.pos;
        fvy_q <= fy.vel;
      end
      OP_EMIT: begin
        o_time_q <= t_q;
        o_px_q   <= fpx_q;
        o_py_q   <= fpy_q;
        o_vx_q   <= fvx_q;
        o_vy_q   <= fvy_q;
        o_st_q   <= ST_OK;
        o_last_q <= last_c;
        idx_q    <= idx_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.cmd      = cmd_q;
    stat_o.dt_zero  = (dt_q == '0);
    stat_o.notraj   = (cvy_q == '0) || (vy_pos && !inc_q);
    stat_o.num_ok   = num_ok;
    stat_o.n_zero   = (n_q == '0);
    stat_o.rest     = rest_c;
    stat_o.last     = last_c;
    stat_o.div_done = div_done;
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign sample_time_o = o_time_q;
  assign out_pos_x_o   = o_px_q;
  assign out_pos_y_o   = o_py_q;
  assign out_vel_x_o   = o_vx_q;
  assign out_vel_y_o   = o_vy_q;
  assign status_o      = o_st_q;
  assign last_o        = o_last_q;

endmodule

FILE: rtl/core/puck_motion_predictor.sv
// ----------------------------------------------------------------------------
// Puck motion predictor
// Tracks an object's position and velocity on a table and predicts its
// motion with reflection at the walls; configured through an APB-style port.
// ----------------------------------------------------------------------------
// A request enters on the input channel when in_valid_i and in_ready_o are
// both high; in_ready_o is high only while the block is between requests.
// Results leave on the output channel, one per handshake, and last_o marks
// the final result of a request. Move divides for each velocity axis
// unless dt is zero; orient needs no division. A predict squares the
// speed and, unless at rest, finds the displacement and a modulo per axis.
// A trajectory divides for arrival time and sample count, then for each
// sample's time before the predict steps, on the shared one-bit-per-cycle
// divider. Results pass through an output register, so a new request is
// taken while the last result still waits; a stalled receiver holds the
// block only when the next result is due. Reset clears the motion state to
// zero and loads the default configuration; no clearing pass is needed.
// Users write registers only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module puck_motion_predictor import pmp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic [31:0]        dt_i,
  input  logic               include_return_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        sample_time_o,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  cfg_t     cfg_q;
  dp_op_e   op;
  dp_stat_t stat;
  logic     wr_en;
  reg_e     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_width   <= 31'd6553600;
      cfg_q.table_length  <= 31'd13107200;
      cfg_q.radius        <= 31'd327680;
      cfg_q.rest_speed_sq <= 32'd1;
      cfg_q.spacing_us    <= 20'd10000;
      cfg_q.max_samples   <= 6'(SampleLimit);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TABLE_WIDTH:   cfg_q.table_width   <= pwdata[30:0];
        REG_TABLE_LENGTH:  cfg_q.table_length  <= pwdata[30:0];
        REG_RADIUS:        cfg_q.radius        <= pwdata[30:0];
        REG_REST_SPEED_SQ: cfg_q.rest_speed_sq <= pwdata;
        REG_SPACING_US:    cfg_q.spacing_us    <= pwdata[19:0];
        REG_MAX_SAMPLES:   cfg_q.max_samples   <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TABLE_WIDTH:   prdata = 32'(cfg_q.table_width);
      REG_TABLE_LENGTH:  prdata = 32'(cfg_q.table_length);
      REG_RADIUS:        prdata = 32'(cfg_q.radius);
      REG_REST_SPEED_SQ: prdata = cfg_q.rest_speed_sq;
      REG_SPACING_US:    prdata = 32'(cfg_q.spacing_us);
      REG_MAX_SAMPLES:   prdata = 32'(cfg_q.max_samples);
      default:           prdata = '0;
    endcase
  end

  pmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  pmp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .stat_o           (stat),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .vel_x_i          (vel_x_i),
    .vel_y_i          (vel_y_i),
    .dt_i             (dt_i),
    .include_return_i (include_return_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .sample_time_o    (sample_time_o),
    .out_pos_x_o      (out_pos_x_o),
    .out_pos_y_o      (out_pos_y_o),
    .out_vel_x_o      (out_vel_x_o),
    .out_vel_y_o      (out_vel_y_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule
